>>> src/gpsl_pkg.sv
`timescale 1ns / 1ps

package gpsl_pkg;

  // Working width for the slew arithmetic, wide enough for a shown bank
  // carried a full turn past its limit.
  localparam int AngleW = 16;

  typedef logic signed [AngleW-1:0] angle_t;

  localparam int PitchW = 12;
  localparam int TargetBankW = 13;
  localparam int BankW = 14;
  localparam int CalW = 5;

  typedef logic signed [PitchW-1:0]      pitch_t;
  typedef logic signed [TargetBankW-1:0] target_bank_t;
  typedef logic signed [BankW-1:0]       bank_t;
  typedef logic signed [CalW-1:0]        cal_t;

  localparam angle_t GapStep320 = 16'sd1280;
  localparam angle_t GapStep160 = 16'sd640;
  localparam angle_t GapStep80  = 16'sd320;
  localparam angle_t GapStep40  = 16'sd160;
  localparam angle_t GapStep20  = 16'sd80;
  localparam angle_t GapSnap    = 16'sd10;

  localparam angle_t Step320 = 16'sd320;
  localparam angle_t Step160 = 16'sd160;
  localparam angle_t Step80  = 16'sd80;
  localparam angle_t Step40  = 16'sd40;
  localparam angle_t Step20  = 16'sd20;
  localparam angle_t Step10  = 16'sd10;

  localparam angle_t FlipGap   = 16'sd4800;
  localparam angle_t FullTurn  = 16'sd5760;
  localparam angle_t BankLimit = 16'sd5760;

  localparam cal_t CalLimit = 5'sd10;

endpackage

>>> src/gpsl_slew.sv
`timescale 1ns / 1ps

module gpsl_slew (
  input  gpsl_pkg::angle_t now_i,
  input  gpsl_pkg::angle_t target_i,
  output gpsl_pkg::angle_t next_o
);
  import gpsl_pkg::*;

  angle_t gap;
  angle_t step;
  logic   snap;

  assign gap = (target_i > now_i) ? angle_t'(target_i - now_i) : angle_t'(now_i - target_i);

  always_comb begin
    snap = 1'b0;
    step = Step10;
    priority if (gap > GapStep320) begin
      step = Step320;
    end else if (gap > GapStep160) begin
      step = Step160;
    end else if (gap > GapStep80) begin
      step = Step80;
    end else if (gap > GapStep40) begin
      step = Step40;
    end else if (gap > GapStep20) begin
      step = Step20;
    end else if (gap > GapSnap) begin
      step = Step10;
    end else begin
      snap = 1'b1;
    end
  end

  always_comb begin
    if (snap) begin
      next_o = target_i;
    end else if (now_i < target_i) begin
      next_o = angle_t'(now_i + step);
    end else begin
      next_o = angle_t'(now_i - step);
    end
  end

endmodule

>>> src/gpsl_cal.sv
`timescale 1ns / 1ps

module gpsl_cal (
  input  gpsl_pkg::cal_t cal_now_i,
  input  gpsl_pkg::cal_t cal_target_i,
  output gpsl_pkg::cal_t cal_next_o
);
  import gpsl_pkg::*;

  always_comb begin
    priority if (cal_now_i > cal_target_i && cal_now_i > -CalLimit) begin
      cal_next_o = cal_t'(cal_now_i - 5'sd1);
    end else if (cal_now_i < cal_target_i && cal_now_i < CalLimit) begin
      cal_next_o = cal_t'(cal_now_i + 5'sd1);
    end else begin
      cal_next_o = cal_now_i;
    end
  end

endmodule

>>> src/gauge_pointer_slew_limiter.sv
`timescale 1ns / 1ps

// Stepped slew limiter for an attitude display. Each input transfer is one
// tick: the shown pitch and bank move toward their targets by a step chosen
// from the size of the gap, and the calibration offset moves by one toward
// cal_target within +/-CalLimit. The block takes one transfer per cycle while
// the output is not stalled; each result passes the input register and the
// result register on either side of one pass of compare-and-add logic that
// also updates the held angles in the same cycle. The calibration register
// may be written at any time the block is idle and is always ready.
module gauge_pointer_slew_limiter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gpsl_pkg::pitch_t              in_target_pitch,
  input  gpsl_pkg::target_bank_t        in_target_bank,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gpsl_pkg::pitch_t              out_pitch_shown,
  output gpsl_pkg::bank_t               out_bank_shown,
  output gpsl_pkg::cal_t                out_cal_shown,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  gpsl_pkg::cal_t                cfg_cal_target
);
  import gpsl_pkg::*;

  logic         in_valid_r;
  pitch_t       tp_r;
  target_bank_t tb_r;
  logic         out_valid_r;
  pitch_t       pitch_out_r;
  bank_t        bank_out_r;
  cal_t         cal_out_r;
  pitch_t       pitch_now_r;
  bank_t        bank_now_r;
  cal_t         cal_now_r;
  cal_t         cal_target_r;

  logic   accept;
  logic   advance;
  logic   fire;
  angle_t pitch_now_w;
  angle_t pitch_tgt_w;
  angle_t pitch_nxt_w;
  angle_t bank_now_w;
  angle_t bank_tgt_w;
  angle_t bank_gap;
  angle_t bank_pre;
  angle_t bank_slew;
  angle_t bank_clamp;
  bank_t  bank_nxt;
  pitch_t pitch_nxt;
  cal_t   cal_nxt;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_pitch_shown = pitch_out_r;
  assign out_bank_shown  = bank_out_r;
  assign out_cal_shown   = cal_out_r;

  assign pitch_now_w = {{(AngleW-PitchW){pitch_now_r[PitchW-1]}}, pitch_now_r};
  assign pitch_tgt_w = {{(AngleW-PitchW){tp_r[PitchW-1]}}, tp_r};
  assign bank_now_w  = {{(AngleW-BankW){bank_now_r[BankW-1]}}, bank_now_r};
  assign bank_tgt_w  = {{(AngleW-TargetBankW){tb_r[TargetBankW-1]}}, tb_r};

  gpsl_slew u_pitch_slew (
    .now_i    (pitch_now_w),
    .target_i (pitch_tgt_w),
    .next_o   (pitch_nxt_w)
  );
  assign pitch_nxt = pitch_nxt_w[PitchW-1:0];

  // A bank gap of more than 300 degrees is closed the short way round.
  assign bank_gap = (bank_tgt_w > bank_now_w) ? angle_t'(bank_tgt_w - bank_now_w)
                                              : angle_t'(bank_now_w - bank_tgt_w);

  always_comb begin
    if (bank_gap > FlipGap) begin
      if (bank_now_w < bank_tgt_w) begin
        bank_pre = angle_t'(bank_now_w + FullTurn);
      end else begin
        bank_pre = angle_t'(bank_now_w - FullTurn);
      end
    end else begin
      bank_pre = bank_now_w;
    end
  end

  gpsl_slew u_bank_slew (
    .now_i    (bank_pre),
    .target_i (bank_tgt_w),
    .next_o   (bank_slew)
  );

  always_comb begin
    priority if (bank_slew > BankLimit) begin
      bank_clamp = BankLimit;
    end else if (bank_slew < -BankLimit) begin
      bank_clamp = -BankLimit;
    end else begin
      bank_clamp = bank_slew;
    end
  end
  assign bank_nxt = bank_clamp[BankW-1:0];

  gpsl_cal u_cal (
    .cal_now_i    (cal_now_r),
    .cal_target_i (cal_target_r),
    .cal_next_o   (cal_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pitch_now_r  <= '0;
      bank_now_r   <= '0;
      cal_now_r    <= '0;
      cal_target_r <= '0;
    end else begin
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      out_valid_r <= fire || (out_valid_r && out_stall);
      if (fire) begin
        pitch_now_r <= pitch_nxt;
        bank_now_r  <= bank_nxt;
        cal_now_r   <= cal_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        cal_target_r <= cfg_cal_target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tp_r <= in_target_pitch;
      tb_r <= in_target_bank;
    end
    if (fire) begin
      pitch_out_r <= pitch_nxt;
      bank_out_r  <= bank_nxt;
      cal_out_r   <= cal_nxt;
    end
  end

endmodule

>>> src/gpsl_checker.sv
`timescale 1ns / 1ps

module gpsl_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input gpsl_pkg::pitch_t       out_pitch_shown,
  input gpsl_pkg::bank_t        out_bank_shown,
  input gpsl_pkg::cal_t         out_cal_shown
);
  import gpsl_pkg::*;

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pitch_shown)
      && $stable(out_bank_shown) && $stable(out_cal_shown))
    else $error("result changed while stalled");

  // The input side only backs up when a result is waiting on a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bank_shown <= 14'sd5760 && out_bank_shown >= -14'sd5760)
    else $error("shown bank outside its limits");

  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cal_shown <= CalLimit && out_cal_shown >= -CalLimit)
    else $error("shown calibration outside its limits");

endmodule

bind gauge_pointer_slew_limiter gpsl_checker u_gpsl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pitch_shown (out_pitch_shown),
  .out_bank_shown  (out_bank_shown),
  .out_cal_shown   (out_cal_shown)
);
